>>> hdl/rtphp_pkg.sv
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared types and codes for the RTP header parser blocks.
// ----------------------------------------------------------------------------
package rtphp_pkg;

  localparam logic [1:0] KIND_CSRC    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_SHORT   = 2'd2;

  localparam int unsigned POS_W = 7;
  localparam int unsigned HLEN_W = 19;
  localparam logic [POS_W-1:0] FIXED_HDR_BYTES = 7'd12;

  localparam logic [POS_W-1:0] POS_SEQ_END  = 7'd3;
  localparam logic [POS_W-1:0] POS_TS_END   = 7'd7;
  localparam logic [POS_W-1:0] POS_SSRC_END = 7'd11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } rtphp_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       csrc_word;
    logic              padding_flag;
    logic              extension_flag;
    logic [3:0]        source_count;
    logic              marker_flag;
    logic [6:0]        payload_type;
    logic [15:0]       sequence_number;
    logic [31:0]       time_stamp;
    logic [31:0]       sync_source;
    logic [15:0]       ext_length;
    logic [HLEN_W-1:0] header_length;
  } rtphp_result_t;

endpackage

>>> hdl/rtphp_in_stage.sv
// ----------------------------------------------------------------------------
// RTP header parser input stage
// Registers one incoming byte transaction ahead of the parse logic.
// ----------------------------------------------------------------------------
module rtphp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtphp_pkg::rtphp_item_t in_item,
  output logic                 item_valid,
  input  logic                 item_take,
  output rtphp_pkg::rtphp_item_t item
);

  logic                   valid_r, valid_nxt;
  rtphp_pkg::rtphp_item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hdl/rtphp_parser.sv
// ----------------------------------------------------------------------------
// RTP header parser core
// Holds the per-packet parse state and forms the result for each byte that gives one.
// ----------------------------------------------------------------------------
module rtphp_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  input  rtphp_pkg::rtphp_item_t   item,
  output logic                     item_take,
  input  logic                     res_space,
  output logic                     res_valid,
  output rtphp_pkg::rtphp_result_t res
);

  logic [rtphp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]                 shift_r, shift_nxt;
  logic [31:0]                 ts_r, ts_nxt;
  logic [31:0]                 ssrc_r, ssrc_nxt;
  logic [15:0]                 seq_r, seq_nxt;
  logic [13:0]                 flags_r, flags_nxt;
  logic                        done_r, done_nxt;

  logic                        active;
  logic [rtphp_pkg::POS_W-1:0] p;
  logic [31:0]                 shift_base;
  logic [rtphp_pkg::POS_W-1:0] csrc_end;
  logic [rtphp_pkg::POS_W-1:0] hend;
  logic [rtphp_pkg::POS_W:0]   p_inc;
  logic [3:0]                  cc;
  logic                        ext;
  logic                        csrc_done;
  logic                        complete;
  logic                        has_res;
  logic [rtphp_pkg::HLEN_W-1:0] ext_bytes;

  assign active     = item.first_byte || !done_r;
  assign p          = item.first_byte ? '0 : pos_r;
  assign shift_base = item.first_byte ? 32'd0 : shift_r;
  assign shift_nxt  = {shift_base[23:0], item.data_byte};
  assign p_inc      = {1'b0, p} + 8'd1;

  always_comb begin
    flags_nxt = flags_r;
    seq_nxt   = seq_r;
    ts_nxt    = ts_r;
    ssrc_nxt  = ssrc_r;
    if (p == '0) begin
      flags_nxt = {item.data_byte[5:0], 8'h00};
    end else if (p == 7'd1) begin
      flags_nxt = {flags_r[13:8], item.data_byte};
    end else if (p == rtphp_pkg::POS_SEQ_END) begin
      seq_nxt = shift_nxt[15:0];
    end else if (p == rtphp_pkg::POS_TS_END) begin
      ts_nxt = shift_nxt;
    end else if (p == rtphp_pkg::POS_SSRC_END) begin
      ssrc_nxt = shift_nxt;
    end
  end

  assign cc        = flags_nxt[11:8];
  assign ext       = flags_nxt[12];
  assign csrc_end  = rtphp_pkg::FIXED_HDR_BYTES + {1'b0, cc, 2'b00};
  assign hend      = csrc_end + (ext ? 7'd4 : 7'd0);
  assign csrc_done = (p >= rtphp_pkg::FIXED_HDR_BYTES) && (p < csrc_end) && (p[1:0] == 2'd3);
  assign complete  = (p_inc == {1'b0, hend});
  assign pos_nxt   = p_inc[rtphp_pkg::POS_W-1:0];
  assign ext_bytes = ext ? {1'b0, shift_nxt[15:0], 2'b00} : '0;

  assign has_res   = active && (complete || item.last_byte || csrc_done);
  assign item_take = item_valid && (!has_res || res_space);
  assign res_valid = item_valid && has_res && res_space;

  always_comb begin
    res = '0;
    if (complete) begin
      res.kind            = rtphp_pkg::KIND_SUMMARY;
      res.csrc_word       = csrc_done ? shift_nxt : 32'd0;
      res.padding_flag    = flags_nxt[13];
      res.extension_flag  = ext;
      res.source_count    = cc;
      res.marker_flag     = flags_nxt[7];
      res.payload_type    = flags_nxt[6:0];
      res.sequence_number = seq_nxt;
      res.time_stamp      = ts_nxt;
      res.sync_source     = ssrc_nxt;
      res.ext_length      = ext ? shift_nxt[15:0] : 16'd0;
      res.header_length   = {12'd0, hend} + ext_bytes;
    end else if (item.last_byte) begin
      res.kind = rtphp_pkg::KIND_SHORT;
    end else begin
      res.kind      = rtphp_pkg::KIND_CSRC;
      res.csrc_word = shift_nxt;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (active) begin
      done_nxt = complete || item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
      pos_r  <= '0;
    end else if (item_take && active) begin
      done_r <= done_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && active) begin
      shift_r <= shift_nxt;
      flags_r <= flags_nxt;
      seq_r   <= seq_nxt;
      ts_r    <= ts_nxt;
      ssrc_r  <= ssrc_nxt;
    end
  end

endmodule

>>> hdl/rtphp_out_stage.sv
// ----------------------------------------------------------------------------
// RTP header parser output stage
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module rtphp_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_valid,
  output logic                     res_space,
  input  rtphp_pkg::rtphp_result_t res,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rtphp_pkg::rtphp_result_t out_res
);

  logic                     valid_r, valid_nxt;
  rtphp_pkg::rtphp_result_t res_r;

  assign res_space = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

>>> hdl/rtp_header_parser.sv
// ----------------------------------------------------------------------------
// RTP header parser
// Parses the RTP fixed header, CSRC list and extension header, one byte per
// transaction, and reports CSRC words, a header summary or a short-packet
// error.
// ----------------------------------------------------------------------------
// The parser takes one packet byte every clock cycle unless a byte that gives
// a result waits for the result register; each result passes the input
// register and then the result register. Throughput is bound only by the
// combinational parse step between those registers, so bytes stream back to back; while a
// result waits at the output, bytes that give no result keep flowing, and a
// byte that gives a result waits for the result register to free. Bytes
// outside a packet header are dropped.
module rtp_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_csrc_word,
  output logic        out_padding_flag,
  output logic        out_extension_flag,
  output logic [3:0]  out_source_count,
  output logic        out_marker_flag,
  output logic [6:0]  out_payload_type,
  output logic [15:0] out_sequence_number,
  output logic [31:0] out_time_stamp,
  output logic [31:0] out_sync_source,
  output logic [15:0] out_ext_length,
  output logic [18:0] out_header_length
);

  rtphp_pkg::rtphp_item_t   in_item;
  rtphp_pkg::rtphp_item_t   item;
  rtphp_pkg::rtphp_result_t res;
  rtphp_pkg::rtphp_result_t out_res;
  logic                     item_valid;
  logic                     item_take;
  logic                     res_valid;
  logic                     res_space;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.first_byte = in_first_byte;
  assign in_item.last_byte  = in_last_byte;

  rtphp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  rtphp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_space  (res_space),
    .res_valid  (res_valid),
    .res        (res)
  );

  rtphp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_space (res_space),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind            = out_res.kind;
  assign out_csrc_word       = out_res.csrc_word;
  assign out_padding_flag    = out_res.padding_flag;
  assign out_extension_flag  = out_res.extension_flag;
  assign out_source_count    = out_res.source_count;
  assign out_marker_flag     = out_res.marker_flag;
  assign out_payload_type    = out_res.payload_type;
  assign out_sequence_number = out_res.sequence_number;
  assign out_time_stamp      = out_res.time_stamp;
  assign out_sync_source     = out_res.sync_source;
  assign out_ext_length      = out_res.ext_length;
  assign out_header_length   = out_res.header_length;

endmodule

>>> sim/rtphp_parse_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP header parser result checker
// Watches both channels of the parser, keeps its own model of the header
// parse, queues the reports each accepted byte should give and compares every
// report the parser hands out with the oldest one queued.
// ----------------------------------------------------------------------------
module rtphp_parse_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_csrc_word,
  input  logic        out_padding_flag,
  input  logic        out_extension_flag,
  input  logic [3:0]  out_source_count,
  input  logic        out_marker_flag,
  input  logic [6:0]  out_payload_type,
  input  logic [15:0] out_sequence_number,
  input  logic [31:0] out_time_stamp,
  input  logic [31:0] out_sync_source,
  input  logic [15:0] out_ext_length,
  input  logic [18:0] out_header_length,
  output int          fail_count,
  output int          pending_reports
);

  logic [rtphp_pkg::POS_W-1:0] byte_pos;
  logic [31:0]                 shift_word;
  logic [31:0]                 ts_word;
  logic [31:0]                 ssrc_word;
  logic [15:0]                 seq_word;
  logic [15:0]                 ext_len;
  logic                        pad_bit;
  logic                        ext_bit;
  logic                        mark_bit;
  logic [3:0]                  csrc_cnt;
  logic [6:0]                  pt_code;
  logic                        parse_idle;

  rtphp_pkg::rtphp_result_t reports_q[$];
  int errors = 0;

  assign fail_count = errors;

  task automatic clear_header();
    byte_pos   = '0;
    shift_word = '0;
    ts_word    = '0;
    ssrc_word  = '0;
    seq_word   = '0;
    ext_len    = '0;
    pad_bit    = 1'b0;
    ext_bit    = 1'b0;
    mark_bit   = 1'b0;
    csrc_cnt   = '0;
    pt_code    = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
    logic [rtphp_pkg::POS_W-1:0] p;
    logic [rtphp_pkg::POS_W-1:0] csrc_end;
    logic [rtphp_pkg::POS_W-1:0] hdr_end;
    logic [rtphp_pkg::POS_W-1:0] offs;
    logic                        csrc_done;
    logic                        complete;
    rtphp_pkg::rtphp_result_t    rep;
    if (first) begin
      clear_header();
      parse_idle = 1'b0;
    end
    if (parse_idle) return;
    p = byte_pos;
    shift_word = {shift_word[23:0], b};
    case (p)
      7'd0: begin
        pad_bit  = b[5];
        ext_bit  = b[4];
        csrc_cnt = b[3:0];
        mark_bit = 1'b0;
        pt_code  = '0;
      end
      7'd1: begin
        mark_bit = b[7];
        pt_code  = b[6:0];
      end
      rtphp_pkg::POS_SEQ_END:  seq_word  = shift_word[15:0];
      rtphp_pkg::POS_TS_END:   ts_word   = shift_word;
      rtphp_pkg::POS_SSRC_END: ssrc_word = shift_word;
      default: ;
    endcase
    csrc_end  = rtphp_pkg::FIXED_HDR_BYTES + {1'b0, csrc_cnt, 2'b00};
    hdr_end   = csrc_end + (ext_bit ? 7'd4 : 7'd0);
    offs      = p - rtphp_pkg::FIXED_HDR_BYTES;
    csrc_done = (p >= rtphp_pkg::FIXED_HDR_BYTES) && (p < csrc_end) &&
                (offs[1:0] == 2'b11);
    if (ext_bit && p == csrc_end + 7'd3) ext_len = shift_word[15:0];
    complete = (p + 7'd1 == hdr_end);
    byte_pos = p + 7'd1;
    rep = '0;
    if (complete) begin
      parse_idle          = 1'b1;
      rep.kind            = rtphp_pkg::KIND_SUMMARY;
      rep.csrc_word       = csrc_done ? shift_word : 32'd0;
      rep.padding_flag    = pad_bit;
      rep.extension_flag  = ext_bit;
      rep.source_count    = csrc_cnt;
      rep.marker_flag     = mark_bit;
      rep.payload_type    = pt_code;
      rep.sequence_number = seq_word;
      rep.time_stamp      = ts_word;
      rep.sync_source     = ssrc_word;
      rep.ext_length      = ext_bit ? ext_len : 16'd0;
      rep.header_length   = {12'd0, hdr_end} +
                            (ext_bit ? {1'b0, ext_len, 2'b00} : 19'd0);
      reports_q.push_back(rep);
    end else if (last) begin
      parse_idle = 1'b1;
      rep.kind   = rtphp_pkg::KIND_SHORT;
      reports_q.push_back(rep);
    end else if (csrc_done) begin
      rep.kind      = rtphp_pkg::KIND_CSRC;
      rep.csrc_word = shift_word;
      reports_q.push_back(rep);
    end
  endtask

  task automatic match_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic match_report();
    rtphp_pkg::rtphp_result_t want;
    if (reports_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result of kind %0d", out_kind);
      return;
    end
    want = reports_q.pop_front();
    match_field("kind", 32'(out_kind), 32'(want.kind));
    match_field("csrc_word", out_csrc_word, want.csrc_word);
    match_field("padding_flag", 32'(out_padding_flag), 32'(want.padding_flag));
    match_field("extension_flag", 32'(out_extension_flag), 32'(want.extension_flag));
    match_field("source_count", 32'(out_source_count), 32'(want.source_count));
    match_field("marker_flag", 32'(out_marker_flag), 32'(want.marker_flag));
    match_field("payload_type", 32'(out_payload_type), 32'(want.payload_type));
    match_field("sequence_number", 32'(out_sequence_number),
                32'(want.sequence_number));
    match_field("time_stamp", out_time_stamp, want.time_stamp);
    match_field("sync_source", out_sync_source, want.sync_source);
    match_field("ext_length", 32'(out_ext_length), 32'(want.ext_length));
    match_field("header_length", 32'(out_header_length), 32'(want.header_length));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_header();
      parse_idle = 1'b1;
      reports_q.delete();
    end else begin
      if (out_valid && out_ready) match_report();
      if (in_valid && in_ready) parse_byte(in_data_byte, in_first_byte, in_last_byte);
    end
    pending_reports <= reports_q.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP header parser testbench
// Streams directed and random RTP packets, whole, truncated, abandoned and
// stray bytes, into the parser in bursts, stalls the result side on a random
// pattern with one long hold-off, and leaves prediction and comparison to the
// parse checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HEADER_ITEMS = 500;

  typedef enum int {
    PKT_FULL,
    PKT_TRUNC,
    PKT_ABANDON,
    PKT_NOISE
  } pkt_shape_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [31:0] out_csrc_word;
  logic        out_padding_flag;
  logic        out_extension_flag;
  logic [3:0]  out_source_count;
  logic        out_marker_flag;
  logic [6:0]  out_payload_type;
  logic [15:0] out_sequence_number;
  logic [31:0] out_time_stamp;
  logic [31:0] out_sync_source;
  logic [15:0] out_ext_length;
  logic [18:0] out_header_length;

  int fail_count;
  int pending_reports;
  int cycle_count = 0;
  int burst_left  = 0;
  int header_items = 0;

  always #2 clk = ~clk;

  rtp_header_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_first_byte       (in_first_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_csrc_word       (out_csrc_word),
    .out_padding_flag    (out_padding_flag),
    .out_extension_flag  (out_extension_flag),
    .out_source_count    (out_source_count),
    .out_marker_flag     (out_marker_flag),
    .out_payload_type    (out_payload_type),
    .out_sequence_number (out_sequence_number),
    .out_time_stamp      (out_time_stamp),
    .out_sync_source     (out_sync_source),
    .out_ext_length      (out_ext_length),
    .out_header_length   (out_header_length)
  );

  rtphp_parse_check u_parse_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_first_byte       (in_first_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_csrc_word       (out_csrc_word),
    .out_padding_flag    (out_padding_flag),
    .out_extension_flag  (out_extension_flag),
    .out_source_count    (out_source_count),
    .out_marker_flag     (out_marker_flag),
    .out_payload_type    (out_payload_type),
    .out_sequence_number (out_sequence_number),
    .out_time_stamp      (out_time_stamp),
    .out_sync_source     (out_sync_source),
    .out_ext_length      (out_ext_length),
    .out_header_length   (out_header_length),
    .fail_count          (fail_count),
    .pending_reports     (pending_reports)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold one transaction until accepted; a gap may open between bursts.
  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    in_last_byte  <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet(input pkt_shape_t shape);
    logic [7:0] hdr0;
    int hlen;
    int nbytes;
    int npay;
    logic l;
    hdr0 = 8'($urandom);
    if ($urandom_range(0, 1) == 1) hdr0[3:0] = 4'($urandom_range(0, 3));
    hlen = 12 + 4 * int'(hdr0[3:0]) + (hdr0[4] ? 4 : 0);
    npay = 0;
    case (shape)
      PKT_FULL: begin
        nbytes = hlen;
        npay   = $urandom_range(0, 4);
      end
      PKT_TRUNC, PKT_ABANDON: nbytes = $urandom_range(1, hlen - 1);
      default: begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
        return;
      end
    endcase
    for (int i = 0; i < nbytes + npay; i++) begin
      l = (shape != PKT_ABANDON) && (i == nbytes + npay - 1);
      send_byte((i == 0) ? hdr0 : 8'($urandom), i == 0, l);
      if (i < nbytes) header_items++;
    end
  endtask

  initial begin : result_sink
    int span;
    int mode;
    int elapsed;
    bit held;
    held    = 1'b0;
    elapsed = 0;
    @(posedge rst_n);
    forever begin
      if (!held && elapsed > 150) begin
        held = 1'b1;
        repeat (400) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      span = $urandom_range(5, 60);
      mode = $urandom_range(0, 3);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        elapsed++;
      end
    end
  end

  initial begin : byte_source
    int pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_first_byte = 1'b0;
    in_last_byte  = 1'b0;
    out_ready     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drop a stray byte, then a one-byte packet, a restart, a full header and a truncated one.
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hE1, 1'b1, 1'b0);
    repeat (14) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    repeat (2) send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);

    while (header_items < HEADER_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_packet(PKT_FULL);
      else if (pick < 85) send_packet(PKT_TRUNC);
      else if (pick < 95) send_packet(PKT_ABANDON);
      else send_packet(PKT_NOISE);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_reports != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/rtphp_pkg.sv
hdl/rtphp_in_stage.sv
hdl/rtphp_parser.sv
hdl/rtphp_out_stage.sv
hdl/rtp_header_parser.sv
sim/rtphp_parse_check.sv
sim/testbench.sv
